### design/bwhp_pkg.sv
// Shared types and constants for the Butterworth high-pass biquad.
// Used by bwhp_ctrl, bwhp_dp and butterworth_highpass_biquad; no dependencies.
package bwhp_pkg;

    localparam int CFG_IDX_BITS = 2;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    // register map
    localparam cfg_idx_t REG_GAIN   = cfg_idx_t'(0);
    localparam cfg_idx_t REG_FB_ONE = cfg_idx_t'(1);
    localparam cfg_idx_t REG_FB_TWO = cfg_idx_t'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SUMW,
        ST_DIFF,
        ST_MUL3,
        ST_OUT
    } state_t;

    // which coefficient / operand pair feeds the multiplier
    typedef enum logic [1:0] {
        MUL_FB1,
        MUL_FB2,
        MUL_OUT
    } mul_sel_t;

    typedef struct packed {
        logic     load_x;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_t;
        logic     acc_w;
        logic     acc_d;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

### design/butterworth_highpass_biquad.sv
// Top level of the second-order Butterworth high-pass biquad (fixed point).
// Depends on bwhp_pkg, bwhp_ctrl and bwhp_dp.
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/tready        sample_in  (Q1.23)
//  m_axis    out        m_axis_tvalid/tready        sample_out (Q1.23, saturated)
//  cfg       in         cfg_valid/cfg_ready         cfg_index, cfg_data (Q2.30 feedback, Q1.31 gain)
//
// The sequencer works on one item at a time and takes no new item before its
// last step, set by the one shared pair of partial-product multipliers used
// three times per sample (b1*w1, b2*w2, a0*d) plus the adder steps between
// them. The steps are MUL1, MUL2, SUMW, DIFF, MUL3 and OUT, which loads the result.
// Reset (aresetn low, synchronous) clears coefficients, history and control.
// A held result stalls the sequencer in its last step; the next item is
// taken in that same cycle the output register frees up.
module butterworth_highpass_biquad #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input samples
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,   // [S-1:0] sample_in, rest zero
    // filtered samples
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_axis_tdata,   // [S-1:0] sample_out, rest zero
    // coefficient writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  bwhp_pkg::cfg_idx_t                cfg_index,
    input  logic [COEF_BITS-1:0]              cfg_data
);

    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    bwhp_pkg::dp_cmd_t  cmd;
    bwhp_pkg::dp_stat_t stat;
    bwhp_pkg::state_t   state;
    logic [SAMPLE_BITS-1:0] sample_out;

    // coefficient registers are always writable, so software must write while idle
    assign cfg_ready = 1'b1;

    bwhp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .cmd     (cmd),
        .state   (state)
    );

    bwhp_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .sample_in  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_out (sample_out),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready)
    );

    assign m_axis_tdata = TDATA_BITS'(sample_out);

`ifndef SYNTH
    // a result is never loaded over one that has not been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten");

    // an accepted item always starts the first multiply
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> (state == bwhp_pkg::ST_MUL1))
        else $error("accepted item did not start processing");

    // a new result only shows up after the final sequencer step
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> ($past(state) == bwhp_pkg::ST_OUT))
        else $error("result raised outside the output step");
`endif

endmodule

### design/bwhp_dp.sv
// Datapath of the high-pass biquad: coefficients, history, split multiplier,
// rounding, saturation and the output register. Depends on bwhp_pkg.
module bwhp_dp #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bwhp_pkg::dp_cmd_t           cmd,
    output bwhp_pkg::dp_stat_t          stat,
    input  logic [SAMPLE_BITS-1:0]      sample_in,
    input  logic                        cfg_we,
    input  bwhp_pkg::cfg_idx_t          cfg_index,
    input  logic [COEF_BITS-1:0]        cfg_data,
    output logic [SAMPLE_BITS-1:0]      sample_out,
    output logic                        out_valid,
    input  logic                        out_ready
);

    localparam int S  = SAMPLE_BITS;
    localparam int C  = COEF_BITS;
    localparam int H  = 2 * S;              // history width
    localparam int A  = H + 4;              // working width for sums
    localparam int L  = (A > 64) ? 64 : A;  // intermediate results held to at most 64 bits
    localparam int BW = A - S;              // multiplier B operand width
    localparam int MW = C + BW;             // partial product width
    localparam int PW = MW + S + 1;         // recombined product width

    logic signed [C-1:0]  gain_reg, fb1_reg, fb2_reg;
    logic signed [H-1:0]  hist1_reg, hist2_reg;
    logic signed [S-1:0]  x_reg;
    logic signed [MW-1:0] prod_hi_reg, prod_lo_reg;
    logic signed [A-1:0]  t_reg, d_reg;
    logic signed [H-1:0]  w_reg;
    logic [S-1:0]         out_reg;
    logic                 out_valid_reg;

    logic signed [C-1:0]  coef_op;
    logic signed [A-1:0]  val_op;
    logic signed [BW-1:0] hi_op, lo_op;
    logic signed [PW-1:0] full, rnd_fb, sh_fb, rnd_o, sh_o;
    logic signed [A-1:0]  q_fb, x_ext, t_next, sum_w, d1, d2, d_next;
    logic signed [H-1:0]  w_next;
    logic [A-H:0]         w_top;
    logic [PW-S:0]        y_top;
    logic [S-1:0]         y_next;

    // hold an A-bit value to the L-bit range
    function automatic logic signed [A-1:0] sat_l(input logic signed [A-1:0] v);
        logic [A-L:0]        top;
        logic                ok;
        logic signed [L-1:0] r;
        top = v[A-1:L-1];
        ok  = (&top) | (~|top);
        r   = ok ? v[L-1:0] : {v[A-1], {(L-1){~v[A-1]}}};
        return A'(r);
    endfunction

    // operand select
    always_comb begin
        case (cmd.mul_sel)
            bwhp_pkg::MUL_FB2: begin
                coef_op = fb2_reg;
                val_op  = A'(hist2_reg);
            end
            bwhp_pkg::MUL_OUT: begin
                coef_op = gain_reg;
                val_op  = d_reg;
            end
            default: begin
                coef_op = fb1_reg;
                val_op  = A'(hist1_reg);
            end
        endcase
        hi_op = val_op[A-1:S];
        lo_op = BW'(val_op[S-1:0]);
    end

    always_comb begin
        full   = (PW'(prod_hi_reg) <<< S) + PW'(prod_lo_reg);
        // feedback terms: round half up, drop C-2 fraction bits
        rnd_fb = full + (PW'(1) <<< (C - 3));
        sh_fb  = rnd_fb >>> (C - 2);
        q_fb   = sat_l(sh_fb[A-1:0]);

        x_ext  = A'(x_reg);
        t_next = sat_l((x_ext <<< 1) + q_fb);

        sum_w  = sat_l(t_reg + q_fb);
        w_top  = sum_w[A-1:H-1];
        w_next = ((&w_top) | (~|w_top)) ? sum_w[H-1:0]
                                         : {sum_w[A-1], {(H-1){~sum_w[A-1]}}};

        d1     = sat_l(A'(w_reg) - A'(hist1_reg));
        d2     = sat_l(d1 - A'(hist1_reg));
        d_next = sat_l(d2 + A'(hist2_reg));

        // output: round half up, drop C-1 bits, saturate to sample width
        rnd_o  = full + (PW'(1) <<< (C - 2));
        sh_o   = rnd_o >>> (C - 1);
        y_top  = sh_o[PW-1:S-1];
        y_next = ((&y_top) | (~|y_top)) ? sh_o[S-1:0]
                                         : {sh_o[PW-1], {(S-1){~sh_o[PW-1]}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg      <= '0;
            fb1_reg       <= '0;
            fb2_reg       <= '0;
            hist1_reg     <= '0;
            hist2_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    bwhp_pkg::REG_GAIN:   gain_reg <= cfg_data;
                    bwhp_pkg::REG_FB_ONE: fb1_reg  <= cfg_data;
                    bwhp_pkg::REG_FB_TWO: fb2_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.acc_d) begin
                hist2_reg <= hist1_reg;
                hist1_reg <= w_reg;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_x) begin
            x_reg <= sample_in;
        end
        if (cmd.mul_en) begin
            prod_hi_reg <= coef_op * hi_op;
            prod_lo_reg <= coef_op * lo_op;
        end
        if (cmd.acc_t) begin
            t_reg <= t_next;
        end
        if (cmd.acc_w) begin
            w_reg <= w_next;
        end
        if (cmd.acc_d) begin
            d_reg <= d_next;
        end
        if (cmd.load_out) begin
            out_reg <= y_next;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign sample_out    = out_reg;
    assign out_valid     = out_valid_reg;

endmodule

### design/bwhp_ctrl.sv
// Sequencer of the high-pass biquad: steps the datapath through one sample.
// Depends on bwhp_pkg.
module bwhp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bwhp_pkg::dp_stat_t stat,
    output bwhp_pkg::dp_cmd_t  cmd,
    output bwhp_pkg::state_t   state
);

    bwhp_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bwhp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = bwhp_pkg::MUL_FB1;
        s_ready     = 1'b0;
        unique case (state_reg)
            bwhp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_x = 1'b1;
                    state_next = bwhp_pkg::ST_MUL1;
                end
            end
            bwhp_pkg::ST_MUL1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = bwhp_pkg::MUL_FB1;
                state_next  = bwhp_pkg::ST_MUL2;
            end
            bwhp_pkg::ST_MUL2: begin
                cmd.acc_t   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = bwhp_pkg::MUL_FB2;
                state_next  = bwhp_pkg::ST_SUMW;
            end
            bwhp_pkg::ST_SUMW: begin
                cmd.acc_w  = 1'b1;
                state_next = bwhp_pkg::ST_DIFF;
            end
            bwhp_pkg::ST_DIFF: begin
                cmd.acc_d  = 1'b1;
                state_next = bwhp_pkg::ST_MUL3;
            end
            bwhp_pkg::ST_MUL3: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = bwhp_pkg::MUL_OUT;
                state_next  = bwhp_pkg::ST_OUT;
            end
            bwhp_pkg::ST_OUT: begin
                cmd.mul_sel = bwhp_pkg::MUL_OUT;
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    s_ready      = 1'b1;
                    if (s_valid) begin
                        cmd.load_x = 1'b1;
                        state_next = bwhp_pkg::ST_MUL1;
                    end else begin
                        state_next = bwhp_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = bwhp_pkg::ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule
